// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== rtl/gn3_pkg.sv =====
`timescale 1ns / 1ps
package gn3_pkg;
	localparam int PERM_N = 256;
	localparam logic [7:0] PERM [PERM_N] = '{
		8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
		8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
		8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
		8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
		8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
		8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
		8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,
		8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
		8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,
		8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
		8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,
		8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
		8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
		8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
		8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
		8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
		8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,
		8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
		8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,
		8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
		8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
		8'd215,8'd61,8'd156,8'd180};
	localparam logic REG_TILE_ENABLE = 1'b0;
	localparam logic REG_TILE_PERIOD = 1'b1;
	localparam int CFG_W = 9;
endpackage

// ===== rtl/gn3_front.sv =====
`timescale 1ns / 1ps
// front: reduces coordinates to cell and fraction, one per cycle unless the output stalls
module gn3_front import gn3_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [31:0] cx,
	input  logic [31:0] cy,
	input  logic [31:0] cz,
	input  logic tile_en,
	input  logic [8:0] period,
	output logic out_valid,
	input  logic out_ready,
	output logic [8*3-1:0] cell0,
	output logic [8*3-1:0] cell1,
	output logic [FRAC_BITS*3-1:0] frac
);
	localparam int IW = 32 - FRAC_BITS;
	// magnitude bits of the integer part, remainder steps per stage
	localparam int AB = IW - 1;
	localparam int STEPS = 3;
	localparam int NST = (AB + STEPS - 1) / STEPS;
	localparam int PB = NST * STEPS;
	logic [8:0] per;
	logic [31:0] c [3];
	logic [7:0] c0 [3];
	logic [7:0] c1 [3];
	// index 0 is the input stage, index k the k-th remainder stage
	logic [NST:0] v_s;
	logic te_s [NST+1];
	logic [8:0] per_s [NST+1];
	logic [7:0] pc_s [NST+1][3];
	logic sg_s [NST+1][3];
	logic [FRAC_BITS-1:0] fr_s [NST+1][3];
	logic [PB-1:0] mag_s [NST+1][3];
	logic [8:0] rem_s [NST+1][3];
	logic adv;
	assign c[0] = cx;
	assign c[1] = cy;
	assign c[2] = cz;
	assign per = (period == 9'd0) ? 9'd1 : (period > 9'd256 ? 9'd256 : period);
	assign adv = !v_s[NST] || out_ready;
	assign in_ready = adv;
	// valid bits of the stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s <= '0;
		else if (adv) v_s <= {v_s[NST-1:0], in_valid};
	end
	// input split, then restoring remainder of the integer magnitude by period
	always_ff @(posedge clk) begin
		if (adv) begin
			te_s[0] <= tile_en;
			per_s[0] <= per;
			for (int i = 0; i < 3; i++) begin
				pc_s[0][i] <= c[i][FRAC_BITS +: 8];
				sg_s[0][i] <= c[i][31];
				fr_s[0][i] <= c[i][FRAC_BITS-1:0];
				// negative integer part is taken as its complement
				mag_s[0][i] <= PB'(c[i][30:FRAC_BITS] ^ {AB{c[i][31]}});
				rem_s[0][i] <= '0;
			end
			for (int k = 0; k < NST; k++) begin
				te_s[k+1] <= te_s[k];
				per_s[k+1] <= per_s[k];
				for (int i = 0; i < 3; i++) begin
					logic [PB-1:0] m;
					logic [9:0] r;
					m = mag_s[k][i];
					r = {1'b0, rem_s[k][i]};
					for (int b = 0; b < STEPS; b++) begin
						r = {r[8:0], m[PB-1]};
						m = m << 1;
						if (r >= {1'b0, per_s[k]}) r = r - {1'b0, per_s[k]};
					end
					pc_s[k+1][i] <= pc_s[k][i];
					sg_s[k+1][i] <= sg_s[k][i];
					fr_s[k+1][i] <= fr_s[k][i];
					mag_s[k+1][i] <= m;
					rem_s[k+1][i] <= r[8:0];
				end
			end
		end
	end
	// cell index: floor mod 256 in plain mode, positive mod period when tiling
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			logic [8:0] r;
			logic [8:0] rn;
			r = rem_s[NST][i];
			// negative integer part: period minus one minus remainder of complement
			if (sg_s[NST][i]) r = per_s[NST] - 9'd1 - r;
			rn = r + 9'd1;
			if (rn == per_s[NST]) rn = 9'd0;
			if (te_s[NST]) begin
				c0[i] = r[7:0];
				c1[i] = rn[7:0];
			end else begin
				c0[i] = pc_s[NST][i];
				c1[i] = pc_s[NST][i] + 8'd1;
			end
		end
	end
	assign out_valid = v_s[NST];
	assign cell0 = {c0[2], c0[1], c0[0]};
	assign cell1 = {c1[2], c1[1], c1[0]};
	assign frac = {fr_s[NST][2], fr_s[NST][1], fr_s[NST][0]};
endmodule

// ===== rtl/gn3_back.sv =====
`timescale 1ns / 1ps
// back: fade, corner hashes, gradients and trilinear blend
module gn3_back import gn3_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [8*3-1:0] cell0,
	input  logic [8*3-1:0] cell1,
	input  logic [FRAC_BITS*3-1:0] frac,
	output logic out_valid,
	input  logic out_ready,
	output logic [15:0] noise
);
	localparam int W = FRAC_BITS + 6;
	localparam int PW = 2 * W;
	localparam logic signed [W-1:0] ONE = W'(1) <<< FRAC_BITS;
	localparam logic signed [PW-1:0] HALF = PW'(1) <<< (FRAC_BITS - 1);
	localparam int NS = 8;
	logic adv;
	logic [NS-1:0] v;
	assign adv = !v[NS-1] || out_ready;
	assign in_ready = adv;
	assign out_valid = v[NS-1];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v <= '0;
		else if (adv) v <= {v[NS-2:0], in_valid};
	end

	function automatic logic signed [W-1:0] fmul(input logic signed [W-1:0] a,
		input logic signed [W-1:0] b);
		logic signed [PW-1:0] p;
		p = PW'(a) * PW'(b) + HALF;
		return W'(p >>> FRAC_BITS);
	endfunction
	function automatic logic signed [W-1:0] gd(input logic [3:0] h,
		input logic signed [W-1:0] x, input logic signed [W-1:0] y,
		input logic signed [W-1:0] z);
		logic signed [W-1:0] u;
		logic signed [W-1:0] w;
		u = (h < 4'd8) ? x : y;
		w = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
		return (h[0] ? -u : u) + (h[1] ? -w : w);
	endfunction

	// s1: first hash level, t squared, t*(6t-15)+10
	logic [7:0] c0_s1 [3];
	logic [7:0] c1_s1 [3];
	logic signed [W-1:0] t_s1 [3];
	logic [7:0] ha_s1 [2];
	logic signed [W-1:0] tt_s1 [3];
	logic signed [W-1:0] in_s1 [3];
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				logic signed [W-1:0] t;
				t = W'({1'b0, frac[i*FRAC_BITS +: FRAC_BITS]});
				c0_s1[i] <= cell0[i*8 +: 8];
				c1_s1[i] <= cell1[i*8 +: 8];
				t_s1[i] <= t;
				tt_s1[i] <= fmul(t, t);
				in_s1[i] <= fmul(t, W'(6 * t - 15 * ONE)) + W'(10 * ONE);
			end
			ha_s1[0] <= PERM[cell0[7:0]];
			ha_s1[1] <= PERM[cell1[7:0]];
		end
	end
	// s2: second hash level, t cubed
	logic [7:0] c0_s2 [3];
	logic [7:0] c1_s2 [3];
	logic signed [W-1:0] t_s2 [3];
	logic signed [W-1:0] t3_s2 [3];
	logic signed [W-1:0] in_s2 [3];
	logic [7:0] hb_s2 [4];
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				c0_s2[i] <= c0_s1[i];
				c1_s2[i] <= c1_s1[i];
				t_s2[i] <= t_s1[i];
				t3_s2[i] <= fmul(tt_s1[i], t_s1[i]);
				in_s2[i] <= in_s1[i];
			end
			for (int j = 0; j < 4; j++)
				hb_s2[j] <= PERM[8'(ha_s1[j & 1] + (j[1] ? c1_s1[1] : c0_s1[1]))];
		end
	end
	// s3: corner hashes, fade weight
	logic [3:0] h_s3 [8];
	logic signed [W-1:0] t_s3 [3];
	logic signed [W-1:0] w_s3 [3];
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				logic signed [W-1:0] w;
				w = fmul(t3_s2[i], in_s2[i]);
				if (w < 0) w = '0;
				if (w > ONE) w = ONE;
				t_s3[i] <= t_s2[i];
				w_s3[i] <= w;
			end
			// corner k: bit0 x, bit1 y, bit2 z
			for (int k = 0; k < 8; k++)
				h_s3[k] <= PERM[8'(hb_s2[(k & 1) | ((k >> 1 & 1) << 1)] +
					(k[2] ? c1_s2[2] : c0_s2[2]))][3:0];
		end
	end
	// s4: gradient dots
	logic signed [W-1:0] g_s4 [8];
	logic signed [W-1:0] w_s4 [3];
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 8; k++)
				g_s4[k] <= gd(h_s3[k], k[0] ? t_s3[0] - ONE : t_s3[0],
					k[1] ? t_s3[1] - ONE : t_s3[1], k[2] ? t_s3[2] - ONE : t_s3[2]);
			w_s4 <= w_s3;
		end
	end
	// s5: blend along x
	logic signed [W-1:0] e_s5 [4];
	logic signed [W-1:0] w_s5 [2];
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < 4; j++)
				e_s5[j] <= g_s4[2*j] + fmul(g_s4[2*j+1] - g_s4[2*j], w_s4[0]);
			w_s5[0] <= w_s4[1];
			w_s5[1] <= w_s4[2];
		end
	end
	// s6: blend along y
	logic signed [W-1:0] f_s6 [2];
	logic signed [W-1:0] w_s6;
	always_ff @(posedge clk) begin
		if (adv) begin
			f_s6[0] <= e_s5[0] + fmul(e_s5[1] - e_s5[0], w_s5[0]);
			f_s6[1] <= e_s5[2] + fmul(e_s5[3] - e_s5[2], w_s5[0]);
			w_s6 <= w_s5[1];
		end
	end
	// s7: blend along z
	logic signed [W-1:0] n_s7;
	always_ff @(posedge clk) begin
		if (adv) n_s7 <= f_s6[0] + fmul(f_s6[1] - f_s6[0], w_s6);
	end
	// s8: map to unsigned q0.16 with saturation
	logic [15:0] o_s8;
	always_ff @(posedge clk) begin
		if (adv) begin
			logic signed [W+8:0] vv;
			vv = (W+9)'(n_s7) + (W+9)'(ONE);
			if (FRAC_BITS > 15)
				vv = (vv + ((W+9)'(1) <<< (FRAC_BITS - 16))) >>> (FRAC_BITS - 15);
			else
				vv = vv <<< (15 - FRAC_BITS);
			if (vv < 0) o_s8 <= 16'd0;
			else if (vv > 65535) o_s8 <= 16'hFFFF;
			else o_s8 <= vv[15:0];
		end
	end
	assign noise = o_s8;
endmodule

// ===== rtl/gradient_noise_3d_point.sv =====
`timescale 1ns / 1ps
// a request passes six front stages, the queue register and eight back stages to the result
// throughput: one point per cycle unless m_tready stalls, front and back are fully pipelined
// front and back are parted by a two-entry queue so either side may stall
// reset clears valid bits and sets tile_enable 0, tile_period 256
module gradient_noise_3d_point import gn3_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata,
	input  logic s_tvalid,
	output logic s_tready,
	// coord_x [31:0], coord_y [63:32], coord_z [95:64]
	input  logic [95:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// noise_value [15:0]
	output logic [15:0] m_tdata
);
	`include "assert_macros.svh"
	localparam int QW = 48 + 3 * FRAC_BITS;
	logic tile_en_q;
	logic [8:0] period_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_en_q <= 1'b0;
			period_q <= 9'd256;
		end else if (cfg_we) begin
			if (cfg_index == REG_TILE_ENABLE) tile_en_q <= cfg_wdata[0];
			else period_q <= cfg_wdata;
		end
	end
	logic fv, fr;
	logic [23:0] fc0, fc1;
	logic [FRAC_BITS*3-1:0] ffr;
	gn3_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk, .arst_n, .in_valid(s_tvalid), .in_ready(s_tready),
		.cx(s_tdata[31:0]), .cy(s_tdata[63:32]), .cz(s_tdata[95:64]),
		.tile_en(tile_en_q), .period(period_q),
		.out_valid(fv), .out_ready(fr), .cell0(fc0), .cell1(fc1), .frac(ffr));
	// two-entry queue between front and back
	logic [QW-1:0] q_q [2];
	logic [1:0] cnt_q;
	logic rd_q;
	logic bv, br;
	logic push, pop;
	assign fr = cnt_q != 2'd2;
	assign push = fv && fr;
	assign bv = cnt_q != 2'd0;
	assign pop = bv && br;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q <= 1'b0;
		end else begin
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
			if (pop) rd_q <= ~rd_q;
		end
	end
	always_ff @(posedge clk) begin
		if (push) q_q[rd_q ^ cnt_q[0] ^ (pop ? 1'b0 : 1'b0)] <= {fc0, fc1, ffr};
	end
	logic [QW-1:0] qh;
	assign qh = q_q[rd_q];
	gn3_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk, .arst_n, .in_valid(bv), .in_ready(br),
		.cell0(qh[QW-1 -: 24]), .cell1(qh[QW-25 -: 24]),
		.frac(qh[FRAC_BITS*3-1:0]),
		.out_valid(m_tvalid), .out_ready(m_tready), .noise(m_tdata));
	`ASSERT_ALWAYS(a_cnt_range, clk, arst_n, cnt_q != 2'd3, "queue count out of range")
	`ASSERT_NEXT(a_full_stall, clk, arst_n, cnt_q == 2'd2 && !pop, !fr,
		"front not stalled on full queue")
	`ASSERT_NEXT(a_cnt_track, clk, arst_n, push && !pop && cnt_q == 2'd0, cnt_q == 2'd1,
		"queue count lost a push")
endmodule
